>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion helper macros
// Implication checks clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/lcdc_pkg.sv
// ---------------------------------------------------------------------------
// lcdc_pkg
// Shared types and constants of the character-LCD command controller.
// ---------------------------------------------------------------------------
`default_nettype none

package lcdc_pkg;

    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] INSTR_CLEAR = 8'h01;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_CGRAM = 2'd1,
        ERR_DDRAM = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RDWAIT,
        ST_CLEAR,
        ST_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic take;      // item accepted this cycle
        logic exec;      // run the latched instruction
        logic mem_wr;    // write latched byte to addressed RAM
        logic mem_rd;    // read addressed RAM
        logic clr_step;  // one entry of the clear sweep
        logic load_out;  // load result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic complete;  // full byte assembled by this item
        logic rs;
        logic rw;
        logic loc_ok;    // address counter points at a real RAM entry
        logic is_clear;
        logic clr_last;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hw/rtl/char_lcd_command_controller.sv
// Steps: decode, RAM read wait or clear sweep if needed, then result register load.
// One item at a time: o_stall stays high until the result is loaded, which waits while a
//   stalled result holds the output register. The clear sweep does one entry per cycle.
// A result may wait in the output register while the next item is processed.
// Reset (synchronous, active low): 8-bit mode, address 0, shift 0, line RAMs read as
//   spaces and glyph RAM as zero at once through per-entry valid bits; no clearing pass.
// ---------------------------------------------------------------------------
// char_lcd_command_controller
// HD44780-style command decoder with display-line and glyph RAMs.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module char_lcd_command_controller #(
    parameter int LINE_CHARS  = 40,
    parameter int GLYPH_BYTES = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire               i_enable,
    input  wire               i_reg_select,
    input  wire               i_read_not_write,
    input  wire  [7:0]        i_bus_data,
    output logic              o_valid,
    input  wire               i_stall,
    output logic [7:0]        o_read_data,
    output logic              o_read_valid,
    output logic [1:0]        o_error_code,
    output logic              o_nibble_pending,
    output logic              o_eight_bit_mode,
    output logic              o_two_lines,
    output logic              o_display_on,
    output logic              o_cursor_on,
    output logic              o_blink_on,
    output logic signed [7:0] o_scroll_offset
);
    import lcdc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lcdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    lcdc_datapath #(
        .LINE_CHARS  (LINE_CHARS),
        .GLYPH_BYTES (GLYPH_BYTES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_enable         (i_enable),
        .i_reg_select     (i_reg_select),
        .i_read_not_write (i_read_not_write),
        .i_bus_data       (i_bus_data),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_read_data      (o_read_data),
        .o_read_valid     (o_read_valid),
        .o_error_code     (o_error_code),
        .o_nibble_pending (o_nibble_pending),
        .o_eight_bit_mode (o_eight_bit_mode),
        .o_two_lines      (o_two_lines),
        .o_display_on     (o_display_on),
        .o_cursor_on      (o_cursor_on),
        .o_blink_on       (o_blink_on),
        .o_scroll_offset  (o_scroll_offset)
    );

    `ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    `ASSERT_IMPL(a_read_no_error, o_valid && o_read_valid, o_error_code == ERR_OK)
    `ASSERT_IMPL(a_nibble_only_4bit, o_valid && o_nibble_pending, !o_eight_bit_mode)
    `ASSERT_IMPL(a_single_ram_op, cmd.mem_wr || cmd.mem_rd, !(cmd.mem_wr && cmd.mem_rd) && !cmd.clr_step)

endmodule

`default_nettype wire

>>> hw/rtl/lcdc_ctrl.sv
// ---------------------------------------------------------------------------
// lcdc_ctrl
// Sequencer: accepts one item, steps the datapath through decode, RAM
// access or clear sweep, and hands the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module lcdc_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  wire                 i_stall,
    input  lcdc_pkg::t_dp_stat  i_stat,
    output lcdc_pkg::t_dp_cmd   o_cmd
);
    import lcdc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_FINISH;
                if (i_stat.complete) begin
                    if (i_stat.rs) begin
                        if (i_stat.loc_ok) begin
                            if (i_stat.rw) begin
                                o_cmd.mem_rd = 1'b1;
                                n_state      = ST_RDWAIT;
                            end else begin
                                o_cmd.mem_wr = 1'b1;
                            end
                        end
                    end else if (!i_stat.rw) begin
                        o_cmd.exec = 1'b1;
                        if (i_stat.is_clear) begin
                            n_state = ST_CLEAR;
                        end
                    end
                end
            end
            ST_RDWAIT: begin
                n_state = ST_FINISH;
            end
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lcdc_datapath.sv
// ---------------------------------------------------------------------------
// lcdc_datapath
// Nibble assembly, instruction execution, mode/address registers, the two
// display-line RAMs and the glyph RAM, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module lcdc_datapath #(
    parameter int LINE_CHARS  = 40,
    parameter int GLYPH_BYTES = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_enable,
    input  wire                 i_reg_select,
    input  wire                 i_read_not_write,
    input  wire  [7:0]          i_bus_data,
    input  lcdc_pkg::t_dp_cmd   i_cmd,
    output lcdc_pkg::t_dp_stat  o_stat,
    output logic [7:0]          o_read_data,
    output logic                o_read_valid,
    output logic [1:0]          o_error_code,
    output logic                o_nibble_pending,
    output logic                o_eight_bit_mode,
    output logic                o_two_lines,
    output logic                o_display_on,
    output logic                o_cursor_on,
    output logic                o_blink_on,
    output logic signed [7:0]   o_scroll_offset
);
    import lcdc_pkg::*;

    localparam int         LW        = $clog2(LINE_CHARS);
    localparam int         GW        = $clog2(GLYPH_BYTES);
    localparam logic [6:0] LINE_LIM  = 7'(LINE_CHARS);
    localparam logic [6:0] GLYPH_LIM = 7'(GLYPH_BYTES);
    localparam logic [LW-1:0] CLR_LAST = LW'(LINE_CHARS - 1);

    // control / mode state
    logic [7:0]    r_latch, n_latch;
    logic          r_phase, n_phase;
    logic          r_complete, n_complete;
    logic          r_rs, n_rs;
    logic          r_rw, n_rw;
    logic [6:0]    r_addr, n_addr;
    logic          r_cgram, n_cgram;
    logic [7:0]    r_shift, n_shift;
    logic          r_dl, n_dl;
    logic          r_n, n_n;
    logic          r_d, n_d;
    logic          r_c, n_c;
    logic          r_b, n_b;
    logic [LW-1:0] r_clr_idx, n_clr_idx;

    // RAMs, valid bits and registered read data
    logic [7:0] l1_mem [LINE_CHARS];
    logic [7:0] l2_mem [LINE_CHARS];
    logic [7:0] g_mem  [GLYPH_BYTES];
    logic [LINE_CHARS-1:0]  r_l1_vld;
    logic [LINE_CHARS-1:0]  r_l2_vld;
    logic [GLYPH_BYTES-1:0] r_g_vld;
    logic [7:0] r_l1_q, r_l2_q, r_g_q;
    logic       r_l1_vq, r_l2_vq, r_g_vq;

    logic          cg_ok, ln_ok, loc_ok;
    logic [LW-1:0] line_idx, l_wr_idx;
    logic [GW-1:0] glyph_idx;
    logic          l1_we, l2_we, g_we;
    logic [7:0]    l_wr_data;
    logic [7:0]    mem_q;
    logic          res_valid;
    logic [7:0]    res_data;
    t_err          res_err;

    logic [7:0]  r_out_data;
    logic        r_out_rvalid;
    t_err        r_out_err;
    logic        r_out_phase, r_out_dl, r_out_n, r_out_d, r_out_c, r_out_b;
    logic [7:0]  r_out_shift;

    // address check: line two lives at 0x40 upward
    assign cg_ok     = (r_addr < GLYPH_LIM);
    assign ln_ok     = ({1'b0, r_addr[5:0]} < LINE_LIM);
    assign loc_ok    = r_cgram ? cg_ok : ln_ok;
    assign line_idx  = r_addr[LW-1:0];
    assign glyph_idx = r_addr[GW-1:0];

    assign o_stat.complete = r_complete;
    assign o_stat.rs       = r_rs;
    assign o_stat.rw       = r_rw;
    assign o_stat.loc_ok   = loc_ok;
    assign o_stat.is_clear = (r_latch == INSTR_CLEAR);
    assign o_stat.clr_last = (r_clr_idx == CLR_LAST);

    always_comb begin
        n_latch    = r_latch;
        n_phase    = r_phase;
        n_complete = r_complete;
        n_rs       = r_rs;
        n_rw       = r_rw;
        n_addr     = r_addr;
        n_cgram    = r_cgram;
        n_shift    = r_shift;
        n_dl       = r_dl;
        n_n        = r_n;
        n_d        = r_d;
        n_c        = r_c;
        n_b        = r_b;
        n_clr_idx  = r_clr_idx;

        if (i_cmd.take) begin
            n_rs       = i_reg_select;
            n_rw       = i_read_not_write;
            n_complete = 1'b0;
            if (i_enable) begin
                priority if (r_dl) begin
                    n_latch    = i_bus_data;
                    n_phase    = 1'b0;
                    n_complete = 1'b1;
                end else if (r_phase) begin
                    n_latch    = r_latch | {4'h0, i_bus_data[7:4]};
                    n_phase    = 1'b0;
                    n_complete = 1'b1;
                end else begin
                    n_latch = {i_bus_data[7:4], 4'h0};
                    n_phase = 1'b1;
                end
            end
        end

        if (i_cmd.exec) begin
            n_clr_idx = '0;
            priority if (r_latch[7]) begin
                n_cgram = 1'b0;
                n_addr  = r_latch[6:0];
            end else if (r_latch[6]) begin
                n_cgram = 1'b1;
                n_addr  = {1'b0, r_latch[5:0]};
            end else if (r_latch[5]) begin
                n_dl = r_latch[4];
                n_n  = r_latch[3];
            end else if (r_latch[4]) begin
                if (r_latch[3]) begin
                    n_shift = r_shift + (r_latch[2] ? 8'h01 : 8'hFF);
                end else begin
                    n_addr = r_addr + (r_latch[2] ? 7'h01 : 7'h7F);
                end
            end else if (r_latch[3]) begin
                n_d = r_latch[2];
                n_c = r_latch[1];
                n_b = r_latch[0];
            end else if (!r_latch[2]) begin
                // home and clear reset position; zero does nothing
                if (r_latch[1] || r_latch[0]) begin
                    n_cgram = 1'b0;
                    n_addr  = '0;
                    n_shift = '0;
                end
            end else begin
                // entry mode set: its flags are not visible on the outputs
            end
        end

        if (i_cmd.clr_step) begin
            n_clr_idx = r_clr_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch    <= '0;
            r_phase    <= 1'b0;
            r_complete <= 1'b0;
            r_rs       <= 1'b0;
            r_rw       <= 1'b0;
            r_addr     <= '0;
            r_cgram    <= 1'b0;
            r_shift    <= '0;
            r_dl       <= 1'b1;
            r_n        <= 1'b0;
            r_d        <= 1'b0;
            r_c        <= 1'b0;
            r_b        <= 1'b0;
            r_clr_idx  <= '0;
        end else begin
            r_latch    <= n_latch;
            r_phase    <= n_phase;
            r_complete <= n_complete;
            r_rs       <= n_rs;
            r_rw       <= n_rw;
            r_addr     <= n_addr;
            r_cgram    <= n_cgram;
            r_shift    <= n_shift;
            r_dl       <= n_dl;
            r_n        <= n_n;
            r_d        <= n_d;
            r_c        <= n_c;
            r_b        <= n_b;
            r_clr_idx  <= n_clr_idx;
        end
    end

    // write ports; the clear sweep writes both lines at the sweep index
    assign l1_we     = i_cmd.clr_step || (i_cmd.mem_wr && !r_cgram && !r_addr[6]);
    assign l2_we     = i_cmd.clr_step || (i_cmd.mem_wr && !r_cgram && r_addr[6]);
    assign g_we      = i_cmd.mem_wr && r_cgram;
    assign l_wr_idx  = i_cmd.clr_step ? r_clr_idx : line_idx;
    assign l_wr_data = i_cmd.clr_step ? SPACE_CHAR : r_latch;

    always_ff @(posedge i_clk) begin
        if (l1_we) begin
            l1_mem[l_wr_idx] <= l_wr_data;
        end
        if (l2_we) begin
            l2_mem[l_wr_idx] <= l_wr_data;
        end
        if (g_we) begin
            g_mem[glyph_idx] <= r_latch;
        end
        if (i_cmd.mem_rd) begin
            r_l1_q <= l1_mem[line_idx];
            r_l2_q <= l2_mem[line_idx];
            r_g_q  <= g_mem[glyph_idx];
        end
    end

    // entries never written since reset read as their reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_vld <= '0;
            r_l2_vld <= '0;
            r_g_vld  <= '0;
            r_l1_vq  <= 1'b0;
            r_l2_vq  <= 1'b0;
            r_g_vq   <= 1'b0;
        end else begin
            if (l1_we) begin
                r_l1_vld[l_wr_idx] <= 1'b1;
            end
            if (l2_we) begin
                r_l2_vld[l_wr_idx] <= 1'b1;
            end
            if (g_we) begin
                r_g_vld[glyph_idx] <= 1'b1;
            end
            if (i_cmd.mem_rd) begin
                r_l1_vq <= r_l1_vld[line_idx];
                r_l2_vq <= r_l2_vld[line_idx];
                r_g_vq  <= r_g_vld[glyph_idx];
            end
        end
    end

    always_comb begin
        priority if (r_cgram) begin
            mem_q = r_g_vq ? r_g_q : 8'h00;
        end else if (r_addr[6]) begin
            mem_q = r_l2_vq ? r_l2_q : SPACE_CHAR;
        end else begin
            mem_q = r_l1_vq ? r_l1_q : SPACE_CHAR;
        end
    end

    assign res_valid = r_complete && r_rw && (!r_rs || loc_ok);

    always_comb begin
        if (!res_valid) begin
            res_data = 8'h00;
        end else if (!r_rs) begin
            res_data = {1'b0, r_addr};  // busy bit always 0
        end else begin
            res_data = mem_q;
        end
    end

    always_comb begin
        if (r_complete && r_rs && !loc_ok) begin
            res_err = r_cgram ? ERR_CGRAM : ERR_DDRAM;
        end else begin
            res_err = ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data   <= res_data;
            r_out_rvalid <= res_valid;
            r_out_err    <= res_err;
            r_out_phase  <= r_phase;
            r_out_dl     <= r_dl;
            r_out_n      <= r_n;
            r_out_d      <= r_d;
            r_out_c      <= r_c;
            r_out_b      <= r_b;
            r_out_shift  <= r_shift;
        end
    end

    assign o_read_data      = r_out_data;
    assign o_read_valid     = r_out_rvalid;
    assign o_error_code     = r_out_err;
    assign o_nibble_pending = r_out_phase;
    assign o_eight_bit_mode = r_out_dl;
    assign o_two_lines      = r_out_n;
    assign o_display_on     = r_out_d;
    assign o_cursor_on      = r_out_c;
    assign o_blink_on       = r_out_b;
    assign o_scroll_offset  = $signed(r_out_shift);

endmodule

`default_nettype wire
